// ===== sv/pestsp_pkg.sv =====
package pestsp_pkg;

	localparam int unsigned ChunkSize = 184;
	localparam int unsigned PktWords = 47;
	localparam logic [7:0] SyncByte = 8'h47;
	localparam logic [7:0] StuffByte = 8'hFF;
	localparam logic [7:0] SidVideo = 8'hE0;
	localparam logic [7:0] SidAudio = 8'hC0;
	localparam logic [7:0] PcrMarker = 8'h7E;
	localparam logic [0:0] ActStart = 1'b0;
	localparam logic [0:0] ActData = 1'b1;
	localparam logic [0:0] CfgVideoPid = 1'b0;
	localparam logic [0:0] CfgAudioPid = 1'b1;

	// descriptor of one packet to build, passed front -> back
	typedef struct packed {
		logic       buf_sel;
		logic [7:0] fill;
		logic       first;
		logic       pcr;
		logic       key;
		logic       audio;
		logic [32:0] clk_ref;
		logic       last_pes;
	} pkt_desc_t;

	function automatic logic [7:0] ts_byte(input logic [32:0] ts, input int unsigned k,
			input logic [7:0] prefix);
		logic [7:0] b;
		case (k)
			0: b = prefix | {4'b0, ts[32:30], 1'b1};
			1: b = ts[29:22];
			2: b = {ts[21:15], 1'b1};
			3: b = ts[14:7];
			default: b = {ts[6:0], 1'b1};
		endcase
		return b;
	endfunction

endpackage

// ===== sv/pestsp_if.sv =====
interface pestsp_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic        stream_is_audio;
	logic [32:0] pts;
	logic [32:0] dts;
	logic        has_dts;
	logic        keyframe;
	logic        pcr_enable;
	logic [31:0] payload_length;
	logic [7:0]  data_byte;
	modport source(output valid, action, stream_is_audio, pts, dts, has_dts, keyframe,
		pcr_enable, payload_length, data_byte, input ready);
	modport sink(input valid, action, stream_is_audio, pts, dts, has_dts, keyframe,
		pcr_enable, payload_length, data_byte, output ready);
endinterface

interface pestsp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] ts_word;
	logic        last_of_packet;
	logic        last_of_pes;
	modport source(output valid, ts_word, last_of_packet, last_of_pes, input ready);
	modport sink(input valid, ts_word, last_of_packet, last_of_pes, output ready);
endinterface

// ===== sv/pes_to_transport_stream_packetizer.sv =====
// PES to transport stream packetizer. A start transaction (action 0) opens a PES and
// writes its header into a chunk buffer, 14 bytes (19 with DTS); the input is not
// ready while the header is written and in the stall state after it. Payload
// transactions (action 1) then take one byte per cycle. Each full chunk, or the last
// byte, closes a 188-byte packet that the back end sends as 47 words, one packet byte
// read per cycle from the buffer while the output does not stall. Two chunk buffers
// let the front fill one while the back sends the other; payload input stalls only
// when both are waiting. The user must write PIDs through the cfg port while idle;
// the block itself does not enforce it.
module pes_to_transport_stream_packetizer
	import pestsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	pestsp_in_if.sink   in_ch,
	pestsp_out_if.source out_ch
);

	logic [12:0] vpid_q, apid_q;
	logic wr_en, wr_sel, desc_push, buf_free;
	logic [7:0] wr_addr, wr_data;
	pkt_desc_t desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpid_q <= 13'd257;
			apid_q <= 13'd258;
		end else if (cfg_we) begin
			if (cfg_index == CfgVideoPid) vpid_q <= cfg_data;
			if (cfg_index == CfgAudioPid) apid_q <= cfg_data;
		end
	end

	pestsp_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.action(in_ch.action), .stream_is_audio(in_ch.stream_is_audio),
		.pts(in_ch.pts), .dts(in_ch.dts), .has_dts(in_ch.has_dts),
		.keyframe(in_ch.keyframe), .pcr_enable(in_ch.pcr_enable),
		.payload_length(in_ch.payload_length[LENGTH_WIDTH-1:0]),
		.data_byte(in_ch.data_byte),
		.wr_en, .wr_sel, .wr_addr, .wr_data, .desc_push, .desc, .buf_free
	);

	pestsp_back u_back (
		.clk, .arst_n,
		.video_pid(vpid_q), .audio_pid(apid_q),
		.wr_en, .wr_sel, .wr_addr, .wr_data, .desc_push, .desc, .buf_free,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.ts_word(out_ch.ts_word), .last_of_packet(out_ch.last_of_packet),
		.last_of_pes(out_ch.last_of_pes)
	);

endmodule

// ===== sv/pestsp_front.sv =====
module pestsp_front
	import pestsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        stream_is_audio,
	input  logic [32:0] pts,
	input  logic [32:0] dts,
	input  logic        has_dts,
	input  logic        keyframe,
	input  logic        pcr_enable,
	input  logic [LENGTH_WIDTH-1:0] payload_length,
	input  logic [7:0]  data_byte,
	// buffer write port
	output logic        wr_en,
	output logic        wr_sel,
	output logic [7:0]  wr_addr,
	output logic [7:0]  wr_data,
	// descriptor push
	output logic        desc_push,
	output pkt_desc_t   desc,
	input  logic        buf_free
);

	// header writes are 19 bytes at most
	typedef enum logic [1:0] {ST_IDLE, ST_HDR, ST_STALL} st_t;

	st_t st_q;
	logic [4:0] hidx_q;
	logic       sel_q;
	logic [7:0] fill_q;
	logic [LENGTH_WIDTH-1:0] rem_q;
	logic first_q, audio_q, key_q, pcr_q, dts_on_q;
	logic [32:0] pts_q, dts_q;
	logic [15:0] pes_len_q;
	logic [7:0] room;
	logic [LENGTH_WIDTH-1:0] rem_dec;
	logic [7:0] hlen;
	logic [7:0] hdr_byte;
	logic data_acc, emit_data;

	assign room = !first_q ? 8'(ChunkSize) : (pcr_q ? 8'(ChunkSize - 8) :
		(key_q ? 8'(ChunkSize - 2) : 8'(ChunkSize)));
	assign rem_dec = rem_q - 1'b1;
	assign hlen = dts_on_q ? 8'd19 : 8'd14;

	// ready: idle and a free buffer to write into
	assign in_ready = (st_q == ST_IDLE) && buf_free;
	assign data_acc = in_valid && in_ready && (action == ActData) && (rem_q != '0);
	assign emit_data = data_acc && ((rem_dec == '0) || (fill_q + 8'd1 >= room));

	always_comb begin
		case (hidx_q)
			5'd0, 5'd1: hdr_byte = 8'h00;
			5'd2: hdr_byte = 8'h01;
			5'd3: hdr_byte = audio_q ? SidAudio : SidVideo;
			5'd4: hdr_byte = pes_len_q[15:8];
			5'd5: hdr_byte = pes_len_q[7:0];
			5'd6: hdr_byte = 8'h80;
			5'd7: hdr_byte = dts_on_q ? 8'hC0 : 8'h80;
			5'd8: hdr_byte = dts_on_q ? 8'd10 : 8'd5;
			5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
				hdr_byte = ts_byte(pts_q, 32'(hidx_q - 5'd9), dts_on_q ? 8'h30 : 8'h20);
			default: hdr_byte = ts_byte(dts_q, 32'(hidx_q - 5'd14), 8'h10);
		endcase
	end

	always_comb begin
		wr_sel = sel_q;
		if (st_q == ST_HDR) begin
			wr_en = 1'b1;
			wr_addr = {3'b0, hidx_q};
			wr_data = hdr_byte;
		end else begin
			wr_en = data_acc && (fill_q < 8'(ChunkSize));
			wr_addr = fill_q;
			wr_data = data_byte;
		end
	end

	// descriptor for the packet being closed
	always_comb begin
		desc.buf_sel = sel_q;
		desc.first = first_q;
		desc.pcr = first_q && pcr_q;
		desc.key = first_q && key_q;
		desc.audio = audio_q;
		desc.clk_ref = dts_on_q ? dts_q : pts_q;
		if (st_q == ST_HDR) begin
			desc.fill = hlen;
			desc.last_pes = 1'b1;
			desc_push = (hidx_q == 5'(hlen - 8'd1)) && (rem_q == '0);
		end else begin
			desc.fill = (fill_q < 8'(ChunkSize)) ? fill_q + 8'd1 : fill_q;
			desc.last_pes = (rem_dec == '0);
			desc_push = emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			hidx_q <= '0;
			sel_q <= 1'b0;
			fill_q <= '0;
			rem_q <= '0;
			first_q <= 1'b0;
			audio_q <= 1'b0;
			key_q <= 1'b0;
			pcr_q <= 1'b0;
			dts_on_q <= 1'b0;
			pts_q <= '0;
			dts_q <= '0;
			pes_len_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready && action == ActStart) begin
						audio_q <= stream_is_audio;
						key_q <= keyframe;
						pcr_q <= pcr_enable;
						dts_on_q <= has_dts;
						pts_q <= pts;
						dts_q <= dts;
						rem_q <= payload_length;
						first_q <= 1'b1;
						pes_len_q <= stream_is_audio ?
							16'(payload_length) + (has_dts ? 16'd13 : 16'd8) : 16'd0;
						hidx_q <= '0;
						st_q <= ST_HDR;
					end else if (data_acc) begin
						rem_q <= rem_dec;
						if (emit_data) begin
							fill_q <= '0;
							first_q <= 1'b0;
							sel_q <= ~sel_q;
						end else begin
							fill_q <= fill_q + 8'd1;
						end
					end
				end
				ST_HDR: begin
					hidx_q <= hidx_q + 5'd1;
					if (hidx_q == 5'(hlen - 8'd1)) begin
						st_q <= ST_STALL;
						if (rem_q == '0) begin
							fill_q <= '0;
							first_q <= 1'b0;
							sel_q <= ~sel_q;
						end else begin
							fill_q <= hlen;
						end
					end
				end
				ST_STALL: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/pestsp_back.sv =====
module pestsp_back
	import pestsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [12:0] video_pid,
	input  logic [12:0] audio_pid,
	input  logic        wr_en,
	input  logic        wr_sel,
	input  logic [7:0]  wr_addr,
	input  logic [7:0]  wr_data,
	input  logic        desc_push,
	input  pkt_desc_t   desc,
	output logic        buf_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] ts_word,
	output logic        last_of_packet,
	output logic        last_of_pes
);

	// two chunk buffers; one is filled while the other is sent
	logic [7:0] mem0 [ChunkSize];
	logic [7:0] mem1 [ChunkSize];
	pkt_desc_t q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	pkt_desc_t  d;
	logic [7:0] pos_q;        // packet byte position being read
	logic [1:0] bsub_q;       // byte within word
	logic [5:0] widx_q;
	logic [23:0] acc_q;
	logic       busy_q;
	logic [7:0] rdata_q;
	logic [7:0] rpos_s1;
	logic       rv_s1;
	logic [3:0] vcc_q, acc_cc_q;
	logic [7:0] alen, dstart, pb, raddr;
	logic       adapt;
	logic [3:0] cc;
	logic       out_busy;
	logic       step;
	logic       word_done;
	logic       pkt_done;

	assign d = q_q[rd_q];
	assign buf_free = (cnt_q != 2'd2);
	assign cc = d.audio ? acc_cc_q : vcc_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel && wr_addr < 8'(ChunkSize)) mem0[wr_addr] <= wr_data;
		if (wr_en && wr_sel && wr_addr < 8'(ChunkSize)) mem1[wr_addr] <= wr_data;
	end

	// adaptation length and payload start
	always_comb begin
		alen = d.pcr ? 8'd8 : (d.key ? 8'd2 : 8'd0);
		adapt = (alen != 8'd0) || (d.fill < 8'(ChunkSize));
		if (d.fill < 8'(ChunkSize) - alen) alen = 8'(ChunkSize) - d.fill;
		dstart = 8'd4 + alen;
		raddr = pos_q - dstart;
	end

	always_comb begin
		if (rpos_s1 >= dstart) pb = rdata_q;
		else begin
			case (rpos_s1)
				8'd0: pb = SyncByte;
				8'd1: pb = {1'b0, d.first, 1'b0,
					(d.audio ? audio_pid[12:8] : video_pid[12:8])};
				8'd2: pb = d.audio ? audio_pid[7:0] : video_pid[7:0];
				8'd3: pb = {2'b0, adapt, 1'b1, cc};
				8'd4: pb = alen - 8'd1;
				8'd5: pb = {1'b0, d.key, 1'b0, d.pcr, 4'b0};
				8'd6: pb = d.pcr ? d.clk_ref[32:25] : StuffByte;
				8'd7: pb = d.pcr ? d.clk_ref[24:17] : StuffByte;
				8'd8: pb = d.pcr ? d.clk_ref[16:9] : StuffByte;
				8'd9: pb = d.pcr ? d.clk_ref[8:1] : StuffByte;
				8'd10: pb = d.pcr ? {d.clk_ref[0], PcrMarker[6:0]} : StuffByte;
				8'd11: pb = d.pcr ? 8'h00 : StuffByte;
				default: pb = StuffByte;
			endcase
		end
	end

	assign out_busy = out_valid && !out_ready;
	// one packet byte per cycle unless the output stalls: read stage, then assembly
	assign step = busy_q && !(rv_s1 && bsub_q == 2'd3 && out_busy);
	assign word_done = step && rv_s1 && (bsub_q == 2'd3);
	assign pkt_done = word_done && (widx_q == 6'(PktWords - 1));

	// read data advances with the read stage only
	always_ff @(posedge clk) begin
		if (step) begin
			rdata_q <= rd_q ? mem1[raddr < 8'(ChunkSize) ? raddr : 8'd0]
				: mem0[raddr < 8'(ChunkSize) ? raddr : 8'd0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			busy_q <= 1'b0;
			pos_q <= '0;
			rpos_s1 <= '0;
			rv_s1 <= 1'b0;
			bsub_q <= '0;
			widx_q <= '0;
			acc_q <= '0;
			out_valid <= 1'b0;
			ts_word <= '0;
			last_of_packet <= 1'b0;
			last_of_pes <= 1'b0;
			vcc_q <= '0;
			acc_cc_q <= '0;
			q_q[0] <= '0;
			q_q[1] <= '0;
		end else begin
			if (word_done) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (desc_push) q_q[desc.buf_sel] <= desc;
			if (!busy_q && cnt_q != 2'd0) begin
				busy_q <= 1'b1;
				pos_q <= '0;
				rv_s1 <= 1'b0;
				bsub_q <= '0;
				widx_q <= '0;
			end else if (step) begin
				rv_s1 <= (pos_q != 8'd188) && !pkt_done;
				rpos_s1 <= pos_q;
				if (pos_q != 8'd188) pos_q <= pos_q + 8'd1;
				if (rv_s1) begin
					bsub_q <= bsub_q + 2'd1;
					if (bsub_q == 2'd3) begin
						ts_word <= {acc_q, pb};
						last_of_packet <= (widx_q == 6'(PktWords - 1));
						last_of_pes <= (widx_q == 6'(PktWords - 1)) && d.last_pes;
						widx_q <= widx_q + 6'd1;
						if (widx_q == 6'(PktWords - 1)) begin
							busy_q <= 1'b0;
							rd_q <= ~rd_q;
							if (d.audio) acc_cc_q <= acc_cc_q + 4'd1;
							else vcc_q <= vcc_q + 4'd1;
						end
					end else begin
						acc_q <= {acc_q[15:0], pb};
					end
				end
			end
			cnt_q <= cnt_q + {1'b0, desc_push} - {1'b0, pkt_done};
		end
	end

endmodule
